[rtl/combined_lcg_shuffle_rng_assert.svh]
// Assertion macros used by the top-level RTL file.
`ifndef COMBINED_LCG_SHUFFLE_RNG_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_RNG_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CRNG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`define CRNG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define CRNG_ASSERT(lbl, clk, rst_n, prop, msg)

`define CRNG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

[rtl/crng_pkg.sv]
`default_nettype none

package crng_pkg;

  localparam int unsigned STREAMS    = 4;
  localparam int unsigned TABLE_SIZE = 32;

  localparam int unsigned VAL_W      = 31;
  localparam int unsigned SIDX_W     = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);
  localparam int unsigned TADDR_W    = SIDX_W + SLOT_W;
  localparam int unsigned TBL_DEPTH  = STREAMS * TABLE_SIZE;
  localparam int unsigned SEED_STEPS = TABLE_SIZE + 8;
  localparam int unsigned STEP_W     = $clog2(SEED_STEPS);

  localparam int unsigned A_W    = 16;
  localparam int unsigned FOLD_W = 8;
  localparam int unsigned PROD_W = A_W + VAL_W;
  localparam int unsigned SUM_W  = VAL_W + 1;

  localparam logic [VAL_W-1:0]  M1            = 31'd2147483563;
  localparam logic [VAL_W-1:0]  M2            = 31'd2147483399;
  localparam logic [A_W-1:0]    A1            = 16'd40014;
  localparam logic [A_W-1:0]    A2            = 16'd40692;
  localparam logic [FOLD_W-1:0] K1            = 8'd85;
  localparam logic [FOLD_W-1:0] K2            = 8'd249;
  localparam logic [VAL_W-1:0]  M1_LESS_ONE   = M1 - 31'd1;
  localparam logic [VAL_W-1:0]  GEN_TWO_RESET = 31'd123456789;

  localparam int unsigned       SLOT_SHIFT = VAL_W - SLOT_W;
  localparam logic [VAL_W-1:0]  SLOT_DIV   = VAL_W'(32'd1 + M1_LESS_ONE / TABLE_SIZE);

  typedef enum logic {
    ACT_SEED = 1'b0,
    ACT_DRAW = 1'b1
  } act_e;

  typedef enum logic {
    GEN_ONE = 1'b0,
    GEN_TWO = 1'b1
  } gen_e;

  typedef enum logic [7:0] {
    ST_CLR   = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_RD    = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_FIN   = 8'b0001_0000,
    ST_SLOAD = 8'b0010_0000,
    ST_SRED  = 8'b0100_0000,
    ST_SSTEP = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [VAL_W-1:0] gen_one;
    logic [VAL_W-1:0] gen_two;
    logic [VAL_W-1:0] last_out;
  } strm_t;

  typedef struct packed {
    logic               we;
    logic [TADDR_W-1:0] waddr;
    logic [VAL_W-1:0]   wdata;
    logic               re;
    logic [TADDR_W-1:0] raddr;
  } tbl_req_t;

  // floor(last / SLOT_DIV) mod TABLE_SIZE; SLOT_DIV sits two below a power of two
  function automatic logic [SLOT_W-1:0] slot_of(input logic [VAL_W-1:0] last);
    logic [SLOT_W-1:0]     q0;
    logic [SLOT_SHIFT:0]   rem;
    q0  = last[VAL_W-1:SLOT_SHIFT];
    rem = {1'b0, last[SLOT_SHIFT-1:0]} + {{(SLOT_SHIFT-SLOT_W){1'b0}}, q0, 1'b0};
    if (rem >= (SLOT_SHIFT+1)'(SLOT_DIV)) begin
      slot_of = q0 + SLOT_W'(1);
    end else begin
      slot_of = q0;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/crng_modmul.sv]
`default_nettype none

module crng_modmul (
  input  wire logic                    clk_i,
  input  wire crng_pkg::gen_e          gen_i,
  input  wire logic [crng_pkg::VAL_W-1:0] x_i,
  output logic [crng_pkg::VAL_W-1:0]   r_o
);

  logic [crng_pkg::A_W-1:0]              mult_a;
  logic [crng_pkg::PROD_W-1:0]           prod_d, prod_q;
  crng_pkg::gen_e                        gen_q;
  logic [crng_pkg::A_W-1:0]              hi;
  logic [crng_pkg::VAL_W-1:0]            lo;
  logic [crng_pkg::FOLD_W-1:0]           fold_k;
  logic [crng_pkg::VAL_W-1:0]            modulus;
  logic [crng_pkg::A_W+crng_pkg::FOLD_W-1:0] fold;
  logic [crng_pkg::SUM_W-1:0]            sum;
  logic [crng_pkg::VAL_W-1:0]            r_d, r_q;

  always_comb begin
    mult_a = (gen_i == crng_pkg::GEN_TWO) ? crng_pkg::A2 : crng_pkg::A1;
    prod_d = crng_pkg::PROD_W'(mult_a) * crng_pkg::PROD_W'(x_i);
  end

  // fold the high part back: 2^31 == K (mod M)
  always_comb begin
    hi      = prod_q[crng_pkg::PROD_W-1:crng_pkg::VAL_W];
    lo      = prod_q[crng_pkg::VAL_W-1:0];
    fold_k  = (gen_q == crng_pkg::GEN_TWO) ? crng_pkg::K2 : crng_pkg::K1;
    modulus = (gen_q == crng_pkg::GEN_TWO) ? crng_pkg::M2 : crng_pkg::M1;
    fold    = (crng_pkg::A_W+crng_pkg::FOLD_W)'(hi) * (crng_pkg::A_W+crng_pkg::FOLD_W)'(fold_k);
    sum     = crng_pkg::SUM_W'(fold) + crng_pkg::SUM_W'(lo);
    if (sum >= crng_pkg::SUM_W'(modulus)) begin
      r_d = crng_pkg::VAL_W'(sum - crng_pkg::SUM_W'(modulus));
    end else begin
      r_d = crng_pkg::VAL_W'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    gen_q  <= gen_i;
    r_q    <= r_d;
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

[rtl/crng_table.sv]
`default_nettype none

module crng_table (
  input  wire logic                       clk_i,
  input  wire crng_pkg::tbl_req_t         req_i,
  output logic [crng_pkg::VAL_W-1:0]      rdata_o
);

  logic [crng_pkg::VAL_W-1:0] mem [crng_pkg::TBL_DEPTH];
  logic [crng_pkg::VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/combined_lcg_shuffle_rng.sv]
// Draw: states RD (state and table read), MUL and FIN (table RMW, output load) follow the
//   transfer, through the two-stage modular multiply; FIN holds while the output stalls.
// Seed: 40 generator steps through SRED and SSTEP in the multiply loop; items never overlap.
// Item with an unused stream index: accepted, no result.
// Reset: asynchronous; afterwards a clearing pass over all STREAMS*TABLE_SIZE entries (128)
//   loads the stream state and zeros the shuffle table while in_stall_o stays high.
`default_nettype none

`include "combined_lcg_shuffle_rng_assert.svh"

module combined_lcg_shuffle_rng (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic [1:0]                    stream_i,
  input  wire logic [crng_pkg::VAL_W-1:0]    seed_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [crng_pkg::VAL_W-1:0]         random_value_o
);

  crng_pkg::state_e                  state_q, state_d;
  logic [crng_pkg::TADDR_W-1:0]      clr_addr_q, clr_addr_d;
  logic [crng_pkg::STEP_W-1:0]       step_q, step_d;
  logic                              out_valid_q, out_valid_d;
  logic [crng_pkg::VAL_W-1:0]        out_value_q, out_value_d;
  logic [crng_pkg::SIDX_W-1:0]       sidx_q;
  logic [crng_pkg::VAL_W-1:0]        seed_q;
  logic [crng_pkg::SLOT_W-1:0]       slot_q, slot_d;
  crng_pkg::strm_t                   rd_q;

  crng_pkg::strm_t                   st_mem [crng_pkg::STREAMS];
  logic                              st_we;
  logic [crng_pkg::SIDX_W-1:0]       st_waddr;
  crng_pkg::strm_t                   st_wdata;

  crng_pkg::tbl_req_t                tbl_req;
  logic [crng_pkg::VAL_W-1:0]        tbl_rdata;

  logic [crng_pkg::VAL_W-1:0]        x1, r1, r2;
  logic [crng_pkg::VAL_W-1:0]        y_val;
  logic [crng_pkg::SLOT_W-1:0]       rd_slot;
  logic [crng_pkg::SIDX_W-1:0]       in_sidx;
  logic [crng_pkg::VAL_W-1:0]        in_seed;
  logic                              in_xfer, stream_ok, out_free, clr_last;

  assign in_stall_o = (state_q != crng_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign stream_ok  = (32'(stream_i) < crng_pkg::STREAMS);
  assign in_sidx    = crng_pkg::SIDX_W'(stream_i);
  assign in_seed    = (seed_value_i == '0) ? crng_pkg::VAL_W'(1) : seed_value_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clr_last   = (clr_addr_q == crng_pkg::TADDR_W'(crng_pkg::TBL_DEPTH - 1));
  assign rd_slot    = crng_pkg::slot_of(rd_q.last_out);

  crng_modmul u_mul_one (
    .clk_i (clk_i),
    .gen_i (crng_pkg::GEN_ONE),
    .x_i   (x1),
    .r_o   (r1)
  );

  crng_modmul u_mul_two (
    .clk_i (clk_i),
    .gen_i (crng_pkg::GEN_TWO),
    .x_i   (rd_q.gen_two),
    .r_o   (r2)
  );

  crng_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  // combine with shuffle entry; wrap into 1 .. M1-1
  always_comb begin
    logic [crng_pkg::VAL_W+1:0] diff;
    logic                       adj;
    diff  = {2'b00, tbl_rdata} - {2'b00, r2};
    adj   = diff[crng_pkg::VAL_W+1] || (diff == '0);
    y_val = tbl_rdata - r2 + (adj ? crng_pkg::M1_LESS_ONE : '0);
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    step_d      = step_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    tbl_req     = '0;
    st_we       = 1'b0;
    st_waddr    = sidx_q;
    st_wdata    = rd_q;
    x1          = rd_q.gen_one;

    case (state_q)
      crng_pkg::ST_CLR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = clr_addr_q;
        tbl_req.wdata = '0;
        st_we         = (32'(clr_addr_q) < crng_pkg::STREAMS);
        st_waddr      = clr_addr_q[crng_pkg::SIDX_W-1:0];
        st_wdata      = '{gen_one: crng_pkg::VAL_W'(1),
                          gen_two: crng_pkg::GEN_TWO_RESET,
                          last_out: '0};
        if (clr_last) begin
          state_d = crng_pkg::ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + crng_pkg::TADDR_W'(1);
        end
      end
      crng_pkg::ST_IDLE: begin
        if (in_xfer && stream_ok) begin
          step_d = crng_pkg::STEP_W'(crng_pkg::SEED_STEPS - 1);
          if (action_i == crng_pkg::ACT_DRAW) begin
            state_d = crng_pkg::ST_RD;
          end else begin
            state_d = crng_pkg::ST_SLOAD;
          end
        end
      end
      crng_pkg::ST_RD: begin
        slot_d        = rd_slot;
        tbl_req.re    = 1'b1;
        tbl_req.raddr = {sidx_q, rd_slot};
        state_d       = crng_pkg::ST_MUL;
      end
      crng_pkg::ST_MUL: begin
        state_d = crng_pkg::ST_FIN;
      end
      crng_pkg::ST_FIN: begin
        if (out_free) begin
          tbl_req.we    = 1'b1;
          tbl_req.waddr = {sidx_q, slot_q};
          tbl_req.wdata = r1;
          st_we         = 1'b1;
          st_wdata      = '{gen_one: r1, gen_two: r2, last_out: y_val};
          out_valid_d   = 1'b1;
          out_value_d   = y_val;
          state_d       = crng_pkg::ST_IDLE;
        end
      end
      crng_pkg::ST_SLOAD: begin
        x1      = seed_q;
        state_d = crng_pkg::ST_SRED;
      end
      crng_pkg::ST_SRED: begin
        state_d = crng_pkg::ST_SSTEP;
      end
      crng_pkg::ST_SSTEP: begin
        x1 = r1;
        if (32'(step_q) < crng_pkg::TABLE_SIZE) begin
          tbl_req.we    = 1'b1;
          tbl_req.waddr = {sidx_q, step_q[crng_pkg::SLOT_W-1:0]};
          tbl_req.wdata = r1;
        end
        if (step_q == '0) begin
          st_we    = 1'b1;
          st_wdata = '{gen_one: r1, gen_two: seed_q, last_out: r1};
          state_d  = crng_pkg::ST_IDLE;
        end else begin
          step_d  = step_q - crng_pkg::STEP_W'(1);
          state_d = crng_pkg::ST_SRED;
        end
      end
      default: begin
        state_d = crng_pkg::ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crng_pkg::ST_CLR;
      clr_addr_q  <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    slot_q      <= slot_d;
    if (in_xfer) begin
      sidx_q <= in_sidx;
      seed_q <= in_seed;
    end
  end

  // stream state memory; reads only on a transfer, writes in the clearing pass or after the read is consumed
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (in_xfer && stream_ok) begin
      rd_q <= st_mem[in_sidx];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_value_q;

  `CRNG_ASSERT(a_out_nonzero, clk_i, rst_ni, out_valid_o |-> (random_value_o != '0), "zero result transferred")
  `CRNG_ASSERT(a_tbl_no_rw, clk_i, rst_ni, tbl_req.re |-> !tbl_req.we, "table read and write overlap")
  `CRNG_ASSERT_NEXT(a_fin_loads, clk_i, rst_ni, (state_q == crng_pkg::ST_FIN) && out_free, out_valid_o && (random_value_o == $past(y_val)), "draw result not loaded")
  `CRNG_ASSERT_NEXT(a_seed_done, clk_i, rst_ni, (state_q == crng_pkg::ST_SSTEP) && (step_q == '0), state_q == crng_pkg::ST_IDLE, "seed loop overrun")

endmodule

`default_nettype wire

[bench/tb_combined_lcg_shuffle_rng.sv]
module tb_combined_lcg_shuffle_rng;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW       = crng_pkg::VAL_W;
  localparam int unsigned NSTREAMS = crng_pkg::STREAMS;
  localparam int unsigned NSLOTS   = crng_pkg::TABLE_SIZE;
  localparam int unsigned RANDOM_PER_PHASE = 175;

  typedef struct {
    crng_pkg::act_e action;
    logic [1:0]     stream;
    logic [VW-1:0]  seed;
  } rng_item_t;

  logic          clk_i          = 1'b0;
  logic          rst_ni         = 1'b0;
  logic          in_valid_i     = 1'b0;
  logic          in_stall_o;
  logic          action_i       = 1'b0;
  logic [1:0]    stream_i       = '0;
  logic [VW-1:0] seed_value_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i    = 1'b0;
  logic [VW-1:0] random_value_o;

  rng_item_t     pending_items[$];
  logic [VW-1:0] expected_values[$];
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct     = 0;
  int unsigned   error_count   = 0;

  logic [VW-1:0] gen_a      [NSTREAMS];
  logic [VW-1:0] gen_b      [NSTREAMS];
  logic [VW-1:0] prev_value [NSTREAMS];
  logic [VW-1:0] shuffle_mem[NSTREAMS][NSLOTS];

  combined_lcg_shuffle_rng u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .stream_i       (stream_i),
    .seed_value_i   (seed_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .random_value_o (random_value_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [VW-1:0] lcg_next(input logic [VW-1:0] x,
                                             input logic [15:0] a,
                                             input logic [VW-1:0] m);
    longint unsigned p;
    p = (64'(a) * 64'(x)) % 64'(m);
    return p[VW-1:0];
  endfunction

  function automatic void rng_seed(input int unsigned s, input logic [VW-1:0] seed);
    logic [VW-1:0] g;
    int            j;
    g = (seed == '0) ? VW'(1) : seed;
    gen_a[s] = g;
    gen_b[s] = g;
    for (j = int'(NSLOTS) + 7; j >= 0; j--) begin
      gen_a[s] = lcg_next(gen_a[s], crng_pkg::A1, crng_pkg::M1);
      if (j < NSLOTS) begin
        shuffle_mem[s][j] = gen_a[s];
      end
    end
    prev_value[s] = shuffle_mem[s][0];
  endfunction

  function automatic logic [VW-1:0] rng_draw(input int unsigned s);
    int unsigned slot;
    longint      t;
    longint      g;
    longint      y;
    gen_a[s] = lcg_next(gen_a[s], crng_pkg::A1, crng_pkg::M1);
    gen_b[s] = lcg_next(gen_b[s], crng_pkg::A2, crng_pkg::M2);
    slot = (prev_value[s] / crng_pkg::SLOT_DIV) % NSLOTS;
    t = longint'(shuffle_mem[s][slot]);
    g = longint'(gen_b[s]);
    y = t - g;
    shuffle_mem[s][slot] = gen_a[s];
    if (y < 1) begin
      y = y + longint'(crng_pkg::M1_LESS_ONE);
    end
    prev_value[s] = y[VW-1:0];
    return prev_value[s];
  endfunction

  function automatic void add_item(input crng_pkg::act_e action, input logic [1:0] stream,
                                   input logic [VW-1:0] seed);
    rng_item_t it;
    it.action = action;
    it.stream = stream;
    it.seed   = seed;
    pending_items.push_back(it);
  endfunction

  function automatic void add_random_item();
    logic [1:0]    stream;
    logic [VW-1:0] seed;
    stream = 2'($urandom_range(3));
    seed   = VW'($urandom());
    if ($urandom_range(99) < 14) begin
      case ($urandom_range(9))
        0: seed = '0;
        1: seed = crng_pkg::M1 + VW'($urandom_range(84));
        2: seed = VW'($urandom_range(1, 1000));
        default: ;
      endcase
      add_item(crng_pkg::ACT_SEED, stream, seed);
    end else begin
      add_item(crng_pkg::ACT_DRAW, stream, seed);
    end
  endfunction

  // predict on each input transfer, then present the next item or idle
  always @(posedge clk_i) begin
    rng_item_t next_item;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (action_i == crng_pkg::ACT_DRAW) begin
          expected_values.push_back(rng_draw(32'(stream_i)));
        end else begin
          rng_seed(32'(stream_i), seed_value_i);
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid_i   <= 1'b1;
          action_i     <= next_item.action;
          stream_i     <= next_item.stream;
          seed_value_i <= next_item.seed;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic [VW-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_values.size() == 0) begin
          $error("random_value: no result expected, actual %0d", random_value_o);
          error_count++;
        end else begin
          want = expected_values.pop_front();
          if (random_value_o !== want) begin
            $error("random_value mismatch: expected %0d, actual %0d", want, random_value_o);
            error_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_values.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    int unsigned s;
    int unsigned k;
    int unsigned phase;
    for (s = 0; s < NSTREAMS; s++) begin
      gen_a[s]      = VW'(1);
      gen_b[s]      = crng_pkg::GEN_TWO_RESET;
      prev_value[s] = '0;
      for (k = 0; k < NSLOTS; k++) begin
        shuffle_mem[s][k] = '0;
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // draws on the reset state, then seeds at the edges of the range
    add_item(crng_pkg::ACT_DRAW, 2'd0, '0);
    add_item(crng_pkg::ACT_DRAW, 2'd3, '1);
    add_item(crng_pkg::ACT_DRAW, 2'd0, '0);
    add_item(crng_pkg::ACT_SEED, 2'd0, '0);
    add_item(crng_pkg::ACT_DRAW, 2'd0, '1);
    add_item(crng_pkg::ACT_DRAW, 2'd0, '0);
    add_item(crng_pkg::ACT_SEED, 2'd1, crng_pkg::M1 - VW'(1));
    add_item(crng_pkg::ACT_DRAW, 2'd1, '0);
    add_item(crng_pkg::ACT_SEED, 2'd2, crng_pkg::M1);
    add_item(crng_pkg::ACT_DRAW, 2'd2, '0);
    add_item(crng_pkg::ACT_DRAW, 2'd2, '0);
    add_item(crng_pkg::ACT_DRAW, 2'd2, '0);
    add_item(crng_pkg::ACT_SEED, 2'd3, '1);
    add_item(crng_pkg::ACT_DRAW, 2'd3, '0);
    add_item(crng_pkg::ACT_SEED, 2'd1, crng_pkg::M1 + VW'(1));
    add_item(crng_pkg::ACT_DRAW, 2'd1, '1);
    add_item(crng_pkg::ACT_SEED, 2'd0, VW'(1));
    add_item(crng_pkg::ACT_DRAW, 2'd0, '0);
    add_item(crng_pkg::ACT_DRAW, 2'd1, '0);
    add_item(crng_pkg::ACT_DRAW, 2'd3, '0);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        add_random_item();
      end
      // hold the sender until every draw of this phase is back
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
